FILE: hdl/hup_pkg.sv
// Package for the HTTP URL parser: beat types, byte class codes and constants.
// No dependencies; imported by http_url_parser_top.
package hup_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_beat;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [2:0]  byte_class;
        logic        out_last;
        logic        url_valid;
        logic [15:0] port_number;
        logic        uses_tls;
        logic        target_needs_slash;
    } t_out_beat;

    localparam logic [2:0] CLS_SCHEME = 3'd0;
    localparam logic [2:0] CLS_SEP    = 3'd1;
    localparam logic [2:0] CLS_HOST   = 3'd2;
    localparam logic [2:0] CLS_DELIM  = 3'd3;
    localparam logic [2:0] CLS_PORT   = 3'd4;
    localparam logic [2:0] CLS_TARGET = 3'd5;
    localparam logic [2:0] CLS_DROP   = 3'd6;

    localparam logic [16:0] PORT_MAX  = 17'd65535;
    localparam logic [16:0] PORT_SAT  = 17'd65536;
    localparam logic [15:0] PORT_HTTP = 16'd80;
    localparam logic [15:0] PORT_TLS  = 16'd443;
    localparam logic [2:0]  DIGIT_SAT = 3'd6;
    localparam logic [7:0]  CTRL_LIMIT = 8'h20;
    localparam logic [7:0]  CTRL_DEL   = 8'h7f;
    localparam logic [7:0]  CASE_OFFS  = 8'h20;

    function automatic logic port_ok(input logic [16:0] accum, input logic [2:0] count);
        return (count >= 3'd1) && (count <= 3'd5) && (accum != 17'd0) && (accum <= PORT_MAX);
    endfunction

endpackage

FILE: hdl/http_url_parser_top.sv
// HTTP URL parser top level: tags each URL byte and gives the verdict on the last beat.
// Depends on hup_pkg.
// The result beat is registered: it appears in the cycle after its input beat is accepted.
// Throughput: one beat per cycle while the output is taken; the parse state and the result register update together.
// The input is ready whenever the result register is empty or is being taken.
// Reset (synchronous, active low) empties the result register and returns the parse state
// to the first scheme letter; the state also returns there after every last beat.
module http_url_parser_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  hup_pkg::t_in_beat i_in_beat,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output hup_pkg::t_out_beat o_out_beat
);
    import hup_pkg::*;

    localparam logic [3:0] PH_H     = 4'd0;
    localparam logic [3:0] PH_T1    = 4'd1;
    localparam logic [3:0] PH_T2    = 4'd2;
    localparam logic [3:0] PH_P     = 4'd3;
    localparam logic [3:0] PH_SC    = 4'd4;
    localparam logic [3:0] PH_C     = 4'd5;
    localparam logic [3:0] PH_SL1   = 4'd6;
    localparam logic [3:0] PH_SL2   = 4'd7;
    localparam logic [3:0] PH_AST   = 4'd8;
    localparam logic [3:0] PH_HOST  = 4'd9;
    localparam logic [3:0] PH_BHOST = 4'd10;
    localparam logic [3:0] PH_ABRK  = 4'd11;
    localparam logic [3:0] PH_PORT  = 4'd12;
    localparam logic [3:0] PH_TGT   = 4'd13;
    localparam logic [3:0] PH_FRAG  = 4'd14;
    localparam logic [3:0] PH_SINK  = 4'd15;

    logic [3:0]  r_phase, n_phase;
    logic [16:0] r_acc, n_acc;
    logic [2:0]  r_cnt, n_cnt;
    logic        r_host, n_host;
    logic        r_err, n_err;
    logic        r_tls, n_tls;
    logic        r_tgt, n_tgt;
    logic        r_slash, n_slash;
    logic        r_out_valid;
    t_out_beat   r_out, n_out;

    logic        in_fire;
    logic [7:0]  b;
    logic [7:0]  lc;
    logic        term;
    logic        go_tgt;
    logic [2:0]  cls;
    logic [20:0] prod;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    assign b    = i_in_beat.in_byte;
    assign lc   = (b >= "A" && b <= "Z") ? b + CASE_OFFS : b;
    assign term = (b == "/") || (b == "?") || (b == "#");
    assign prod = {4'd0, r_acc} * 21'd10 + {13'd0, b - "0"};

    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        n_host  = r_host;
        n_err   = r_err;
        n_tls   = r_tls;
        n_tgt   = r_tgt;
        n_slash = r_slash;
        go_tgt  = 1'b0;
        cls     = CLS_SCHEME;
        n_out   = '0;

        if (b < CTRL_LIMIT || b == CTRL_DEL) begin
            n_err = 1'b1;
        end

        unique case (r_phase)
            PH_H, PH_T1, PH_T2, PH_P: begin
                cls = CLS_SCHEME;
                if ((r_phase == PH_H && lc == "h") || (r_phase == PH_T1 && lc == "t") ||
                    (r_phase == PH_T2 && lc == "t") || (r_phase == PH_P && lc == "p")) begin
                    n_phase = r_phase + 4'd1;
                end else begin
                    n_err   = 1'b1;
                    n_phase = PH_SINK;
                end
            end
            PH_SC: begin
                if (lc == "s") begin
                    n_tls   = 1'b1;
                    n_phase = PH_C;
                    cls     = CLS_SCHEME;
                end else if (b == ":") begin
                    n_phase = PH_SL1;
                    cls     = CLS_SEP;
                end else begin
                    n_err   = 1'b1;
                    n_phase = PH_SINK;
                    cls     = CLS_SCHEME;
                end
            end
            PH_C, PH_SL1, PH_SL2: begin
                cls = CLS_SEP;
                if ((r_phase == PH_C && b == ":") || (r_phase != PH_C && b == "/")) begin
                    n_phase = r_phase + 4'd1;
                end else begin
                    n_err   = 1'b1;
                    n_phase = PH_SINK;
                end
            end
            PH_AST: begin
                if (term) begin
                    n_err  = 1'b1;
                    go_tgt = 1'b1;
                end else if (b == "[") begin
                    n_phase = PH_BHOST;
                    cls     = CLS_DELIM;
                end else if (b == ":") begin
                    n_err   = 1'b1;
                    n_phase = PH_PORT;
                    cls     = CLS_DELIM;
                end else begin
                    if (b == "@") begin
                        n_err = 1'b1;
                    end
                    n_host  = 1'b1;
                    n_phase = PH_HOST;
                    cls     = CLS_HOST;
                end
            end
            PH_HOST: begin
                if (term) begin
                    go_tgt = 1'b1;
                end else if (b == ":") begin
                    n_phase = PH_PORT;
                    cls     = CLS_DELIM;
                end else begin
                    if (b == "@") begin
                        n_err = 1'b1;
                    end
                    cls = CLS_HOST;
                end
            end
            PH_BHOST: begin
                if (term) begin
                    n_err  = 1'b1;
                    go_tgt = 1'b1;
                end else if (b == "]") begin
                    if (!r_host) begin
                        n_err = 1'b1;
                    end
                    n_phase = PH_ABRK;
                    cls     = CLS_DELIM;
                end else begin
                    if (b == "@") begin
                        n_err = 1'b1;
                    end
                    n_host = 1'b1;
                    cls    = CLS_HOST;
                end
            end
            PH_ABRK: begin
                if (term) begin
                    go_tgt = 1'b1;
                end else if (b == ":") begin
                    n_phase = PH_PORT;
                    cls     = CLS_DELIM;
                end else begin
                    n_err = 1'b1;
                    cls   = CLS_DELIM;
                end
            end
            PH_PORT: begin
                if (term) begin
                    if (!port_ok(r_acc, r_cnt)) begin
                        n_err = 1'b1;
                    end
                    go_tgt = 1'b1;
                end else if (b >= "0" && b <= "9") begin
                    n_acc = (prod > {4'd0, PORT_MAX}) ? PORT_SAT : prod[16:0];
                    if (r_cnt < DIGIT_SAT) begin
                        n_cnt = r_cnt + 3'd1;
                    end
                    cls = CLS_PORT;
                end else begin
                    n_err = 1'b1;
                    cls   = (b == ":") ? CLS_DELIM : CLS_PORT;
                end
            end
            PH_TGT: begin
                cls = CLS_TARGET;
                if (b == "#") begin
                    go_tgt = 1'b1;
                end
            end
            default: begin
                cls = CLS_DROP;
            end
        endcase

        if (go_tgt) begin
            if (b == "#") begin
                n_phase = PH_FRAG;
                cls     = CLS_DROP;
            end else begin
                n_phase = PH_TGT;
                cls     = CLS_TARGET;
                if (!r_tgt) begin
                    n_tgt   = 1'b1;
                    n_slash = (b == "?");
                end
            end
        end

        n_out.out_byte   = b;
        n_out.byte_class = cls;
        n_out.out_last   = i_in_beat.in_last;

        if (i_in_beat.in_last) begin
            if (n_phase <= PH_SL2 || n_phase == PH_SINK || n_phase == PH_AST ||
                n_phase == PH_BHOST) begin
                n_err = 1'b1;
            end
            if (n_phase == PH_PORT && !port_ok(n_acc, n_cnt)) begin
                n_err = 1'b1;
            end
            n_out.url_valid = !n_err;
            if (!n_err) begin
                n_out.port_number        = (n_cnt != 3'd0) ? n_acc[15:0] :
                                           (n_tls ? PORT_TLS : PORT_HTTP);
                n_out.uses_tls           = n_tls;
                n_out.target_needs_slash = n_slash;
            end
            n_phase = PH_H;
            n_acc   = '0;
            n_cnt   = '0;
            n_host  = 1'b0;
            n_err   = 1'b0;
            n_tls   = 1'b0;
            n_tgt   = 1'b0;
            n_slash = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_H;
            r_acc       <= '0;
            r_cnt       <= '0;
            r_host      <= 1'b0;
            r_err       <= 1'b0;
            r_tls       <= 1'b0;
            r_tgt       <= 1'b0;
            r_slash     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_phase <= n_phase;
                r_acc   <= n_acc;
                r_cnt   <= n_cnt;
                r_host  <= n_host;
                r_err   <= n_err;
                r_tls   <= n_tls;
                r_tgt   <= n_tgt;
                r_slash <= n_slash;
            end
            if (in_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out <= n_out;
        end
    end

    a_last_resets_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && i_in_beat.in_last |=> r_phase == PH_H && r_cnt == 3'd0)
        else $error("parse state not cleared after last beat");

    a_valid_only_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.url_valid |-> o_out_beat.out_last)
        else $error("verdict on a beat that is not last");

    a_valid_port_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.url_valid |-> o_out_beat.port_number != 16'd0)
        else $error("accepted URL with port zero");

    a_port_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc <= PORT_SAT && r_cnt <= DIGIT_SAT)
        else $error("port accumulator beyond saturation");

    a_count_tracks_accum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 3'd0 |-> r_acc == 17'd0)
        else $error("port value without digits");

endmodule
